FILE: hdl/rsm_pkg.sv
// rsm_pkg: shared types and constants for the residual symbol mapper.
// Holds the context threshold table, escape-bin codes and the result record.
// No dependencies.
package rsm_pkg;

  // Context thresholds, in units of 0.25 (0.25 .. 1.5, then 2 .. 14 in steps of 0.5).
  localparam int NUM_THRESH = 31;
  localparam logic [5:0] QUARTER_THRESH [NUM_THRESH] = '{
    6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd8,  6'd10,
    6'd12, 6'd14, 6'd16, 6'd18, 6'd20, 6'd22, 6'd24, 6'd26,
    6'd28, 6'd30, 6'd32, 6'd34, 6'd36, 6'd38, 6'd40, 6'd42,
    6'd44, 6'd46, 6'd48, 6'd50, 6'd52, 6'd54, 6'd56
  };

  // Sample ranges
  localparam logic [8:0] LUMA_TOP      = 9'd255;
  localparam logic [8:0] CHROMA_TOP    = 9'd511;
  localparam logic [8:0] LUMA_MIRROR   = 9'd128;
  localparam logic [8:0] CHROMA_MIRROR = 9'd256;

  // Model symbols: below DIRECT_LIMIT the symbol is coded as is
  localparam logic [4:0] DIRECT_LIMIT = 5'd16;
  localparam logic [4:0] ESC_BIN_16   = 5'd16;  // 16..31,   4 raw bits
  localparam logic [4:0] ESC_BIN_32   = 5'd17;  // 32..63,   5 raw bits
  localparam logic [4:0] ESC_BIN_64   = 5'd18;  // 64..127,  6 raw bits
  localparam logic [4:0] ESC_BIN_128  = 5'd19;  // 128..255, 7 raw bits
  localparam logic [4:0] ESC_BIN_256  = 5'd20;  // 256..511, 8 raw bits (chroma)

  localparam logic [3:0] RAW_CNT_16  = 4'd4;
  localparam logic [3:0] RAW_CNT_32  = 4'd5;
  localparam logic [3:0] RAW_CNT_64  = 4'd6;
  localparam logic [3:0] RAW_CNT_128 = 4'd7;
  localparam logic [3:0] RAW_CNT_256 = 4'd8;

  typedef struct packed {
    logic [4:0] context_index;
    logic [8:0] folded_symbol;
    logic [4:0] model_symbol;
    logic [7:0] raw_bits;
    logic [3:0] raw_count;
  } rsm_result_t;

endpackage

FILE: hdl/residual_symbol_mapper.sv
// residual_symbol_mapper: per-pixel residual folding with escape bins.
// Depends on rsm_pkg (threshold table, escape-bin codes, result record).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------------
//   in_     | in        | in_valid/in_ready  | pixel_value, left_neighbour,
//           |           |                    | prediction_offset, context_value
//   out_    | out       | out_valid/out_ready| context_index, folded_symbol,
//           |           |                    | model_symbol, raw_bits, raw_count
//   cfg_    | in        | cfg_we (no wait)   | cfg_wdata -> chroma_mode
//
// Items pass the input and result registers; one item per cycle while out_ready is high.
// Stage 1 is an input register, the fold/escape logic sits between it and the result
// register. in_ready falls only when both registers hold items and out_ready is low.
// rst_n (synchronous, active low) empties both stages and sets chroma_mode to luma.
// in_ready follows out_ready combinationally, so a stall reaches the input in the same cycle.
module residual_symbol_mapper #(
  parameter int NUM_CONTEXTS  = 32,  // 2..32
  parameter int FRACTION_BITS = 8    // 2..12
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [8:0]         in_pixel_value,
  input  logic [8:0]         in_left_neighbour,
  input  logic signed [17:0] in_prediction_offset,
  input  logic [15:0]        in_context_value,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_context_index,
  output logic [8:0]         out_folded_symbol,
  output logic [4:0]         out_model_symbol,
  output logic [7:0]         out_raw_bits,
  output logic [3:0]         out_raw_count
);
  import rsm_pkg::*;

  localparam int F  = FRACTION_BITS;
  // Prediction width: offset (18b) or left<<F, plus mirror headroom and sign.
  localparam int DW = ((F + 10 > 18) ? F + 10 : 18) + 2;
  localparam int PW = DW - F + 1;  // integer prediction, room for top - p
  localparam int SW = PW + 2;      // fold arithmetic
  localparam logic [4:0] CTX_MAX = 5'(NUM_CONTEXTS - 1);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic chroma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroma_r <= 1'b0;
    end else if (cfg_we) begin
      chroma_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: two-stage pipeline
  // ---------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic s2_take;   // result register loads from stage 1
  logic s1_take;   // input register loads from the port

  assign s2_take  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_take;
  assign s1_take  = in_valid && in_ready;

  // Stage 1: input register
  logic [8:0]         s1_pixel_r;
  logic [8:0]         s1_left_r;
  logic signed [17:0] s1_offset_r;
  logic [15:0]        s1_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_pixel_r  <= in_pixel_value;
      s1_left_r   <= in_left_neighbour;
      s1_offset_r <= in_prediction_offset;
      s1_ctx_r    <= in_context_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Context quantizer: count thresholds at or below the context value, then cap.
  // Thresholds rise strictly, so the count is the first entry the value is below.
  // ---------------------------------------------------------------------------
  logic [4:0] ctx_cnt;
  logic [4:0] ctx_idx;

  always_comb begin
    ctx_cnt = '0;
    for (int i = 0; i < NUM_THRESH; i++) begin
      if ({1'b0, s1_ctx_r} >= (17'(QUARTER_THRESH[i]) << (F - 2))) begin
        ctx_cnt = ctx_cnt + 5'd1;
      end
    end
    ctx_idx = (ctx_cnt > CTX_MAX) ? CTX_MAX : ctx_cnt;
  end

  // ---------------------------------------------------------------------------
  // Prediction: d = offset + left<<F, p = d / 2^F toward zero
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] off_ext;
  logic signed [DW-1:0] left_ext;
  logic signed [DW-1:0] d;
  logic signed [DW-1:0] d_adj;
  logic signed [PW-1:0] p_t;     // truncated prediction
  logic signed [PW-1:0] p_c;     // after luma clamp
  logic signed [DW+1:0] frac;    // d - p_c<<F, sign tells the rounding side
  logic                 above_pre;
  logic                 below_pre;
  logic                 mirror;
  logic [8:0]           top;
  logic [8:0]           x_c;
  logic [8:0]           xm;
  logic signed [PW-1:0] pm;
  logic                 above;

  always_comb begin
    off_ext  = DW'(s1_offset_r);
    left_ext = DW'({s1_left_r, {F{1'b0}}});
    d        = off_ext + left_ext;
    // bias negatives so the arithmetic shift rounds toward zero
    d_adj    = d + (d[DW-1] ? DW'((1 << F) - 1) : DW'(0));
    p_t      = PW'(d_adj >>> F);

    if (chroma_r) begin
      p_c    = p_t;
      top    = CHROMA_TOP;
      x_c    = s1_pixel_r;
      // signed compare: a negative prediction never mirrors
      mirror = (p_t >= $signed(PW'(CHROMA_MIRROR)));
    end else begin
      if (p_t < 0) begin
        p_c = '0;
      end else if (p_t > PW'(LUMA_TOP)) begin
        p_c = PW'(LUMA_TOP);
      end else begin
        p_c = p_t;
      end
      top    = LUMA_TOP;
      x_c    = (s1_pixel_r > LUMA_TOP) ? LUMA_TOP : s1_pixel_r;
      mirror = (p_c >= PW'(LUMA_MIRROR));
    end

    frac      = (DW+2)'(d) - ((DW+2)'(p_c) <<< F);
    below_pre = frac[DW+1];
    above_pre = !frac[DW+1] && (frac != '0);

    // mirroring about top swaps the side of the fraction
    xm    = mirror ? (top - x_c) : x_c;
    pm    = mirror ? (PW'(top) - p_c) : p_c;
    above = mirror ? below_pre : above_pre;
  end

  // ---------------------------------------------------------------------------
  // Fold residual into a non-negative symbol
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] xs;
  logic signed [SW-1:0] ps;
  logic signed [SW-1:0] sym;
  logic [8:0]           mag;

  always_comb begin
    xs = SW'($signed({1'b0, xm}));
    ps = SW'(pm);
    if (above) begin
      if (xs <= ps) begin
        sym = (ps - xs) <<< 1;
      end else if (xs > (ps <<< 1)) begin
        sym = xs;
      end else begin
        sym = ((xs - ps) <<< 1) - SW'(1);
      end
    end else begin
      if (xs < ps) begin
        sym = ((ps - xs) <<< 1) - SW'(1);
      end else if (xs > (ps <<< 1)) begin
        sym = xs;
      end else begin
        sym = (xs - ps) <<< 1;
      end
    end

    if (sym < 0) begin
      mag = '0;
    end else if (sym > SW'(CHROMA_TOP)) begin
      mag = CHROMA_TOP;
    end else begin
      mag = sym[8:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Escape split
  // ---------------------------------------------------------------------------
  rsm_result_t res;

  always_comb begin
    res.context_index = ctx_idx;
    res.folded_symbol = mag;
    res.model_symbol  = mag[4:0];
    res.raw_bits      = '0;
    res.raw_count     = '0;
    if (mag < 9'd16) begin
      res.model_symbol = mag[4:0];
    end else if (mag < 9'd32) begin
      res.model_symbol = ESC_BIN_16;
      res.raw_bits     = 8'(mag - 9'd16);
      res.raw_count    = RAW_CNT_16;
    end else if (mag < 9'd64) begin
      res.model_symbol = ESC_BIN_32;
      res.raw_bits     = 8'(mag - 9'd32);
      res.raw_count    = RAW_CNT_32;
    end else if (mag < 9'd128) begin
      res.model_symbol = ESC_BIN_64;
      res.raw_bits     = 8'(mag - 9'd64);
      res.raw_count    = RAW_CNT_64;
    end else if (mag < 9'd256 || !chroma_r) begin
      // luma keeps everything from 128 up in this bin, offset saturated
      res.model_symbol = ESC_BIN_128;
      res.raw_bits     = (mag < 9'd256) ? 8'(mag - 9'd128) : 8'd127;
      res.raw_count    = RAW_CNT_128;
    end else begin
      res.model_symbol = ESC_BIN_256;
      res.raw_bits     = 8'(mag - 9'd256);
      res.raw_count    = RAW_CNT_256;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  rsm_result_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_context_index = out_r.context_index;
  assign out_folded_symbol = out_r.folded_symbol;
  assign out_model_symbol  = out_r.model_symbol;
  assign out_raw_bits      = out_r.raw_bits;
  assign out_raw_count     = out_r.raw_count;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a stalled stage-1 item is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_take) |=> s1_valid_r)
    else $error("stage 1 item lost while stalled");

  // raw bits only with an escape bin
  a_raw_direct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.model_symbol < DIRECT_LIMIT) == (out_r.raw_count == '0)))
    else $error("raw count does not match direct/escape symbol");

  // raw offset fits in the announced count
  a_raw_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.raw_count != '0) |->
      ((9'(out_r.raw_bits) >> out_r.raw_count) == '0))
    else $error("raw bits exceed raw count");

  // context index within the configured number of contexts
  a_ctx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.context_index <= CTX_MAX))
    else $error("context index out of range");

endmodule
